@@ src/rmsd3_pkg.sv @@
// ----------------------------------------------------------------------------
// rmsd3_pkg: shared types and constants of the running mean / stddev block
// Holds the controller-to-datapath command and status words and the
// configuration register codes.
// ----------------------------------------------------------------------------
package rmsd3_pkg;

  localparam int AXES = 3;

  typedef logic [1:0] axis_t;

  // configuration register indexes
  localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [1:0] CFG_BASIS_LIMIT  = 2'd1;

  localparam logic [7:0]  SAMPLE_COUNT_RST = 8'd255;
  localparam logic [14:0] BASIS_LIMIT_RST  = 15'd32767;

  localparam logic [23:0] SD_MAX = 24'hFFFFFF;
  localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

  // commands from controller to datapath
  typedef struct packed {
    logic  cap_in;     // capture the input word, open the item
    logic  d1_calc;    // form |X - old mean|
    logic  div1_start; // divide the deviation by the count
    logic  mean_upd;   // form the new mean and second deviation
    logic  mul;        // multiply the two deviation magnitudes
    logic  sum_upd;    // update state, start the variance division
    logic  sqrt_start; // start the square root on the variance
    logic  sd_store;   // keep the standard deviation of this axis
    logic  out_load;   // load the output register, advance the count
    axis_t axis;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } sts_t;

endpackage

@@ src/rmsd3_div.sv @@
// ----------------------------------------------------------------------------
// rmsd3_div: restoring divider by an 8-bit count
// One quotient bit per cycle over the full dividend width.
// ----------------------------------------------------------------------------
module rmsd3_div #(
  parameter int DW = 56
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [7:0]    divisor_i,
  output logic [DW-1:0] quotient_o,
  output logic          done_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q, quo_d;
  logic [7:0]    rem_q, rem_d;
  logic [7:0]    dvs_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [8:0]    trial;
  logic          ge;

  // one restoring step
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
    quo_d = {quo_q[DW-2:0], ge};
  end

  // hold control, advance the iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(DW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) done_q <= 1'b1;
      end
    end
  end

  // datapath words
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

@@ src/rmsd3_sqrt.sv @@
// ----------------------------------------------------------------------------
// rmsd3_sqrt: digit-by-digit integer square root
// Two radicand bits per cycle, floor of the root.
// ----------------------------------------------------------------------------
module rmsd3_sqrt #(
  parameter int VW = 56
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VW-1:0]         value_i,
  output logic [(VW+1)/2-1:0]   root_o,
  output logic                  done_o
);

  localparam int RW  = (VW + 1) / 2;
  localparam int SQW = 2 * RW;
  localparam int CW  = $clog2(RW + 1);

  logic [SQW-1:0]  val_q;
  logic [RW+1:0]   rem_q, rem_d;
  logic [RW-1:0]   root_q, root_d;
  logic [CW-1:0]   cnt_q;
  logic            done_q;
  logic [RW+3:0]   rem_t;
  logic [RW+3:0]   trial;

  // one root digit
  always_comb begin
    rem_t = {rem_q, val_q[SQW-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    if (rem_t >= trial) begin
      rem_d  = (RW+2)'(rem_t - trial);
      root_d = {root_q[RW-2:0], 1'b1};
    end else begin
      rem_d  = rem_t[RW+1:0];
      root_d = {root_q[RW-2:0], 1'b0};
    end
  end

  // hold control, advance the iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(RW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= SQW'(value_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      val_q  <= {val_q[SQW-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

@@ src/rmsd3_ctrl.sv @@
// ----------------------------------------------------------------------------
// rmsd3_ctrl: sequencer of the running mean / stddev block
// Steps each axis through deviation, division, mean, product, sum,
// variance division and square root, then hands the word to the output.
// ----------------------------------------------------------------------------
module rmsd3_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  rmsd3_pkg::sts_t  sts_i,
  output rmsd3_pkg::cmd_t  cmd_o
);

  import rmsd3_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_D1, S_DIVS, S_DIV1, S_MEAN, S_MUL, S_SUM, S_DIV2, S_SQRT, S_OUT
  } state_e;

  state_e state_q, state_d;
  axis_t  axis_q, axis_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // decode commands and next state
  always_comb begin
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    state_d     = state_q;
    axis_d      = axis_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          axis_d       = '0;
          state_d      = S_D1;
        end
      end
      S_D1: begin
        cmd_o.d1_calc = 1'b1;
        state_d       = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.div1_start = 1'b1;
        state_d          = S_DIV1;
      end
      S_DIV1: begin
        if (sts_i.div_done) state_d = S_MEAN;
      end
      S_MEAN: begin
        cmd_o.mean_upd = 1'b1;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_upd = 1'b1;
        state_d       = S_DIV2;
      end
      S_DIV2: begin
        if (sts_i.div_done) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sts_i.sqrt_done) begin
          cmd_o.sd_store = 1'b1;
          if (axis_q == axis_t'(AXES - 1)) begin
            state_d = S_OUT;
          end else begin
            axis_d  = axis_q + 1'b1;
            state_d = S_D1;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

@@ src/rmsd3_dp.sv @@
// ----------------------------------------------------------------------------
// rmsd3_dp: datapath of the running mean / stddev block
// Keeps run state and configuration, the shared divider and square root,
// per-axis results and the output register.
// ----------------------------------------------------------------------------
module rmsd3_dp #(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rmsd3_pkg::cmd_t    cmd_i,
  output rmsd3_pkg::sts_t    sts_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic               restart_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i,
  output logic signed [23:0] mean_x_o,
  output logic signed [23:0] mean_y_o,
  output logic signed [23:0] mean_z_o,
  output logic [23:0]        stddev_x_o,
  output logic [23:0]        stddev_y_o,
  output logic [23:0]        stddev_z_o,
  output logic               done_res_o,
  output logic               basis_fault_o
);

  import rmsd3_pkg::*;

  localparam int F    = FRACTION_BITS;
  localparam int MW   = 16 + F;               // mean and scaled sample
  localparam int DVW  = 17 + F;               // deviation
  localparam int PW   = 2 * DVW;              // deviation product
  localparam int SHW  = PW - F;               // product after scaling
  localparam int SUMW = (SHW > 48 ? SHW : 48) + 1;
  localparam int DW   = 48 + F;               // divider width
  localparam int RW   = (DW + 1) / 2;         // root width

  // configuration
  logic [7:0]  sample_count_q;
  logic [14:0] basis_limit_q;

  // run state
  logic [7:0]           idx_q;
  logic signed [MW-1:0] mean_q [AXES];
  logic [47:0]          sum_q  [AXES];

  // item registers
  logic signed [15:0]    smp_q [AXES];
  logic                  clear_q;
  logic [7:0]            n_q;
  logic                  fault_q;
  logic [DVW-1:0]        mag_d1_q;
  logic                  neg_d1_q;
  logic signed [MW-1:0]  new_mean_q;
  logic [DVW-1:0]        mag_d2_q;
  logic [PW-1:0]         prod_q;
  logic signed [MW-1:0]  res_mean_q [AXES];
  logic [23:0]           res_sd_q   [AXES];

  // output register
  logic signed [23:0] out_mean_q [AXES];
  logic [23:0]        out_sd_q   [AXES];
  logic               out_done_q;
  logic               out_fault_q;

  // working signals
  logic signed [MW-1:0]  x_cur, mean_old, mean_new;
  logic signed [DVW-1:0] d1, d2;
  logic [47:0]           sum_old;
  logic [SUMW-1:0]       sum_wide;
  logic [47:0]           sum_new;
  logic [MW-1:0]         mag_new;
  logic                  fault_axis;
  logic                  div_start;
  logic [DW-1:0]         div_dividend, quotient;
  logic                  div_done, sqrt_done;
  logic [RW-1:0]         root;
  logic [23:0]           sd_sat;
  logic                  run_done;

  // select the current axis and form the arithmetic
  always_comb begin
    x_cur    = MW'(smp_q[cmd_i.axis]) <<< F;
    mean_old = clear_q ? '0 : mean_q[cmd_i.axis];
    sum_old  = clear_q ? '0 : sum_q[cmd_i.axis];
    d1       = DVW'(x_cur) - DVW'(mean_old);
    mean_new = neg_d1_q ? MW'(mean_old - $signed({1'b0, quotient[MW-1:0]}))
                        : MW'(mean_old + $signed({1'b0, quotient[MW-1:0]}));
    d2       = DVW'(x_cur) - DVW'(mean_new);
    sum_wide = SUMW'(sum_old) + SUMW'(prod_q >> F);
    sum_new  = (sum_wide > SUMW'(SUM_MAX)) ? SUM_MAX : sum_wide[47:0];
    mag_new  = new_mean_q[MW-1] ? MW'(-new_mean_q) : MW'(new_mean_q);
    fault_axis = (new_mean_q == '0) || (mag_new > (MW'(basis_limit_q) << F));
    div_start  = cmd_i.div1_start || cmd_i.sum_upd;
    div_dividend = cmd_i.sum_upd ? (DW'(sum_new) << F)
                                 : DW'(mag_d1_q) + DW'(n_q >> 1);
    sd_sat   = ({{24{1'b0}}, root} > {{RW{1'b0}}, SD_MAX}) ? SD_MAX : 24'(root);
    run_done = n_q >= sample_count_q;
  end

  // configuration and run count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= SAMPLE_COUNT_RST;
      basis_limit_q  <= BASIS_LIMIT_RST;
      idx_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[7:0];
          CFG_BASIS_LIMIT:  basis_limit_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.out_load) idx_q <= run_done ? '0 : n_q;
    end
  end

  // item sequencing through the datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      smp_q[0] <= accel_x_i;
      smp_q[1] <= accel_y_i;
      smp_q[2] <= accel_z_i;
      clear_q  <= restart_i || (idx_q == '0);
      n_q      <= ((restart_i || (idx_q == '0)) ? 8'd0 : idx_q) + 8'd1;
      fault_q  <= 1'b0;
    end
    if (cmd_i.d1_calc) begin
      neg_d1_q <= d1[DVW-1];
      mag_d1_q <= d1[DVW-1] ? DVW'(-d1) : DVW'(d1);
    end
    if (cmd_i.mean_upd) begin
      new_mean_q <= mean_new;
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(mag_d2_q) * PW'(mag_d1_q);
    end
    if (cmd_i.sum_upd) begin
      mean_q[cmd_i.axis]     <= new_mean_q;
      sum_q[cmd_i.axis]      <= sum_new;
      res_mean_q[cmd_i.axis] <= new_mean_q;
      fault_q                <= fault_q || fault_axis;
    end
    if (cmd_i.sd_store) begin
      res_sd_q[cmd_i.axis] <= sd_sat;
    end
    if (cmd_i.out_load) begin
      for (int a = 0; a < AXES; a++) begin
        out_mean_q[a] <= 24'(res_mean_q[a]);
        out_sd_q[a]   <= res_sd_q[a];
      end
      out_done_q  <= run_done;
      out_fault_q <= run_done && fault_q;
    end
  end

  // second deviation, taken from the new mean as it is formed
  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_upd) begin
      mag_d2_q <= d2[DVW-1] ? DVW'(-d2) : DVW'(d2);
    end
  end

  rmsd3_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (n_q),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  rmsd3_sqrt #(
    .VW (DW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .value_i (quotient),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  assign sts_o.div_done  = div_done;
  assign sts_o.sqrt_done = sqrt_done;

  assign mean_x_o      = out_mean_q[0];
  assign mean_y_o      = out_mean_q[1];
  assign mean_z_o      = out_mean_q[2];
  assign stddev_x_o    = out_sd_q[0];
  assign stddev_y_o    = out_sd_q[1];
  assign stddev_z_o    = out_sd_q[2];
  assign done_res_o    = out_done_q;
  assign basis_fault_o = out_fault_q;

endmodule

@@ src/running_mean_stddev_3axis.sv @@
// Accepts a new sample only after the last one is through; the axes share one
//   bit-serial divider (one quotient bit a cycle) and one square root (one root
//   bit a cycle), and a stalled result holds the next sample off.
// Reset clears the run count and the handshake, and loads the register defaults.
// ----------------------------------------------------------------------------
// running_mean_stddev_3axis: three-axis running mean and standard deviation
// Welford update per axis with end-of-run flag and mean range check.
// ----------------------------------------------------------------------------
module running_mean_stddev_3axis #(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] mean_x_o,
  output logic signed [23:0] mean_y_o,
  output logic signed [23:0] mean_z_o,
  output logic [23:0]        stddev_x_o,
  output logic [23:0]        stddev_y_o,
  output logic [23:0]        stddev_z_o,
  output logic               done_res_o,
  output logic               basis_fault_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i
);

  import rmsd3_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // registers take a word in any cycle
  assign cfg_ready_o = 1'b1;

  rmsd3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rmsd3_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .accel_x_i     (accel_x_i),
    .accel_y_i     (accel_y_i),
    .accel_z_i     (accel_z_i),
    .restart_i     (restart_i),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mean_x_o      (mean_x_o),
    .mean_y_o      (mean_y_o),
    .mean_z_o      (mean_z_o),
    .stddev_x_o    (stddev_x_o),
    .stddev_y_o    (stddev_y_o),
    .stddev_z_o    (stddev_z_o),
    .done_res_o    (done_res_o),
    .basis_fault_o (basis_fault_o)
  );

endmodule
